/* sv/bba_pkg.sv */
// Shared types, constants and a helper function of the buddy block allocator.
package bba_pkg;

	// Default configuration of the allocator.
	localparam int HEAP_ADDR_BITS_DEF  = 20;
	localparam int MIN_ORDER_DEF       = 5;
	localparam int SLOTS_PER_ORDER_DEF = 32;
	localparam int MIN_GROW_BYTES_DEF  = 16384;
	localparam int MAX_GROW_BYTES_DEF  = 524288;
	localparam int HEADER_BYTES_DEF    = 32;

	// Fixed field widths of the words on the two channels.
	localparam int REQ_W      = 21;
	localparam int UADDR_W    = 20;
	localparam int GADDR_W    = 20;
	localparam int GORDER_W   = 5;
	localparam int STATUS_W   = 2;
	// Width of an order value held inside the block.
	localparam int ORDER_W    = 6;

	// Operation codes.
	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	// Status codes.
	localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_OOM    = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_REJECT = 2'd2;

	typedef struct packed {
		logic                 operation;
		logic [REQ_W-1:0]     request_bytes;
		logic [UADDR_W-1:0]   user_address;
	} in_word_t;

	typedef struct packed {
		logic [STATUS_W-1:0]  status;
		logic [GADDR_W-1:0]   granted_address;
		logic [GORDER_W-1:0]  granted_order;
	} out_word_t;

	// Smallest o with 2^o >= v; each compare is independent of the others.
	function automatic logic [ORDER_W-1:0] clog2_up(input logic [63:0] v);
		logic [ORDER_W-1:0] r;
		r = '0;
		for (int o = 0; o < 63; o++) begin
			if (v > (64'd1 << o)) begin
				r = ORDER_W'(o + 1);
			end
		end
		return r;
	endfunction

endpackage

/* sv/bba_hdr_ram.sv */
// Block header memory: simple dual-port RAM with a registered read.
module bba_hdr_ram #(
	parameter int ADDR_W = 15,
	parameter int DATA_W = 48
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [2**ADDR_W];

	// One write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* sv/bba_slot_ram.sv */
// Free list slot memory: simple dual-port RAM with a registered read.
module bba_slot_ram #(
	parameter int DEPTH  = 512,
	parameter int DATA_W = 21
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [DATA_W-1:0]        wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [DATA_W-1:0]        rdata
);

	logic [DATA_W-1:0] mem [DEPTH];

	// One write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* sv/buddy_block_allocator.sv */
// Top level of the buddy block allocator: sequencer, free list scanner and memories.
//
//   channel | direction | handshake             | word
//   req     | in        | req_valid / req_ready | request (operation, size, address)
//   rsp     | out       | rsp_valid / rsp_ready | response (status, address, order)
//
// After reset the slot memory is swept, one slot a cycle, over all NO*SLOTS_PER_ORDER slots
// (512 with the defaults) before req_ready rises.
// Every free list operation is a scan of one order row through the slot memory port, unless
// the row is skipped (order out of range, or an add to a full row). An allocate costs one scan
// per list operation (one search, one to list a new area, three per split step, one to take
// the block); a free costs one scan to list the block and three scans per merge step.
// One request is in work at a time.
// A response waiting in the output register does not stop the next request from being taken.
module buddy_block_allocator
#(
	parameter int HEAP_ADDR_BITS  = bba_pkg::HEAP_ADDR_BITS_DEF,
	parameter int MIN_ORDER       = bba_pkg::MIN_ORDER_DEF,
	parameter int SLOTS_PER_ORDER = bba_pkg::SLOTS_PER_ORDER_DEF,
	parameter int MIN_GROW_BYTES  = bba_pkg::MIN_GROW_BYTES_DEF,
	parameter int MAX_GROW_BYTES  = bba_pkg::MAX_GROW_BYTES_DEF,
	parameter int HEADER_BYTES    = bba_pkg::HEADER_BYTES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  bba_pkg::in_word_t  req_word,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output bba_pkg::out_word_t rsp_word
);

	import bba_pkg::*;

	localparam int AW    = HEAP_ADDR_BITS;
	localparam int NO    = AW - MIN_ORDER + 1;
	localparam int OIW   = $clog2(NO);
	localparam int NSLOT = NO * SLOTS_PER_ORDER;
	localparam int SAW   = $clog2(NSLOT);
	localparam int SIW   = $clog2(SLOTS_PER_ORDER);
	localparam int CW    = $clog2(SLOTS_PER_ORDER + 1);
	localparam int HIW   = AW - MIN_ORDER;
	localparam int HW    = ORDER_W + 2 * AW + 2;
	localparam int SEW   = AW + 1;
	localparam int SW    = ((AW > 22) ? AW : 22) + 2;

	localparam logic [SW-1:0] HEAP_B = SW'(1) << AW;
	localparam logic [SW-1:0] MIN_B  = SW'(MIN_GROW_BYTES);
	localparam logic [SW-1:0] MAX_B  = SW'(MAX_GROW_BYTES);
	localparam logic [SW-1:0] HDR_B  = SW'(HEADER_BYTES);

	// Sequencer states.
	localparam logic [4:0] ST_CLR      = 5'd0;
	localparam logic [4:0] ST_IDLE     = 5'd1;
	localparam logic [4:0] ST_A_START  = 5'd2;
	localparam logic [4:0] ST_A_SEARCH = 5'd3;
	localparam logic [4:0] ST_A_FOUND  = 5'd4;
	localparam logic [4:0] ST_A_HRD    = 5'd5;
	localparam logic [4:0] ST_A_HCAP   = 5'd6;
	localparam logic [4:0] ST_A_GROW   = 5'd7;
	localparam logic [4:0] ST_A_GWR    = 5'd8;
	localparam logic [4:0] ST_SP_CHK   = 5'd9;
	localparam logic [4:0] ST_SP_A1    = 5'd10;
	localparam logic [4:0] ST_SP_WRF   = 5'd11;
	localparam logic [4:0] ST_SP_WRB   = 5'd12;
	localparam logic [4:0] ST_SP_USE   = 5'd13;
	localparam logic [4:0] ST_A_DONE   = 5'd14;
	localparam logic [4:0] ST_F_START  = 5'd15;
	localparam logic [4:0] ST_F_HRD    = 5'd16;
	localparam logic [4:0] ST_F_HCAP   = 5'd17;
	localparam logic [4:0] ST_F_WR     = 5'd18;
	localparam logic [4:0] ST_M_CHK    = 5'd19;
	localparam logic [4:0] ST_M_BRD    = 5'd20;
	localparam logic [4:0] ST_M_BCAP   = 5'd21;
	localparam logic [4:0] ST_M_D2     = 5'd22;
	localparam logic [4:0] ST_M_WR     = 5'd23;
	localparam logic [4:0] ST_SC_START = 5'd24;
	localparam logic [4:0] ST_SC_RD    = 5'd25;
	localparam logic [4:0] ST_SC_CHK   = 5'd26;
	localparam logic [4:0] ST_SC_END   = 5'd27;
	localparam logic [4:0] ST_FIN      = 5'd28;

	// Scan modes.
	localparam logic [1:0] SC_FIND = 2'd0;
	localparam logic [1:0] SC_ADD  = 2'd1;
	localparam logic [1:0] SC_DEL  = 2'd2;

	logic [4:0]          state_q;
	logic [REQ_W-1:0]    req_q;
	logic [UADDR_W-1:0]  ua_q;
	logic [ORDER_W-1:0]  k_q;
	logic [AW-1:0]       block_q;
	logic [AW-1:0]       bud_q;
	logic                lo_bud_q;
	logic [ORDER_W-1:0]  f_order_q;
	logic [AW-1:0]       f_head_q;
	logic [AW:0]         f_end_q;
	logic                f_used_q;
	logic [ORDER_W-1:0]  tmp_o_q;
	logic [AW:0]         heap_top_q;
	logic [SW-1:0]       grow_q;
	logic [1:0]          sc_mode_q;
	logic [4:0]          sc_ret_q;
	logic [ORDER_W-1:0]  sc_order_q;
	logic [AW-1:0]       sc_key_q;
	logic [SIW-1:0]      sc_idx_q;
	logic [SIW-1:0]      sc_hit_q;
	logic                sc_found_q;
	logic                sc_dup_q;
	logic [AW-1:0]       sc_best_q;
	logic [SAW-1:0]      clr_q;
	logic [CW-1:0]       cnt_q [NO];
	out_word_t           hold_q;
	out_word_t           rsp_q;
	logic                rsp_valid_q;

	// Free list row selection and count of the order under scan.
	logic                ord_ok;
	logic [OIW-1:0]      oi;
	logic [CW-1:0]       cnt_cur;
	logic [SAW-1:0]      row_base;

	assign ord_ok   = (sc_order_q >= ORDER_W'(MIN_ORDER)) && (sc_order_q <= ORDER_W'(AW));
	assign oi       = OIW'(sc_order_q - ORDER_W'(MIN_ORDER));
	assign cnt_cur  = ord_ok ? cnt_q[oi] : '0;
	assign row_base = SAW'(oi * SLOTS_PER_ORDER);

	// Slot memory.
	logic            slot_we;
	logic [SAW-1:0]  slot_waddr;
	logic [SEW-1:0]  slot_wdata;
	logic [SAW-1:0]  slot_raddr;
	logic [SEW-1:0]  slot_rdata;
	logic            sl_valid;
	logic [AW-1:0]   sl_addr;

	assign sl_valid   = slot_rdata[AW];
	assign sl_addr    = slot_rdata[AW-1:0];
	assign slot_raddr = row_base + SAW'(sc_idx_q);

	always_comb begin
		slot_we    = 1'b0;
		slot_waddr = row_base + SAW'(sc_hit_q);
		slot_wdata = '0;
		if (state_q == ST_CLR) begin
			slot_we    = 1'b1;
			slot_waddr = clr_q;
		end else if (state_q == ST_SC_END) begin
			if (sc_mode_q == SC_ADD) begin
				slot_we    = !sc_dup_q && sc_found_q;
				slot_wdata = {1'b1, sc_key_q};
			end else if (sc_mode_q == SC_DEL) begin
				slot_we    = sc_found_q;
			end
		end
	end

	bba_slot_ram #(
		.DEPTH  (NSLOT),
		.DATA_W (SEW)
	) u_slot_ram (
		.clk   (clk),
		.we    (slot_we),
		.waddr (slot_waddr),
		.wdata (slot_wdata),
		.raddr (slot_raddr),
		.rdata (slot_rdata)
	);

	// Header memory, read data unpacked into its fields.
	logic            hdr_we;
	logic [HIW-1:0]  hdr_waddr;
	logic [HW-1:0]   hdr_wdata;
	logic [HIW-1:0]  hdr_raddr;
	logic [HW-1:0]   hdr_rdata;
	logic [ORDER_W-1:0] rd_order;
	logic [AW-1:0]   rd_head;
	logic [AW:0]     rd_end;
	logic            rd_used;
	logic [AW-1:0]   back_addr;
	logic [AW-1:0]   lo_addr;

	assign rd_order  = hdr_rdata[HW-1 -: ORDER_W];
	assign rd_head   = hdr_rdata[2*AW+1 -: AW];
	assign rd_end    = hdr_rdata[AW+1 -: AW+1];
	assign rd_used   = hdr_rdata[0];
	assign back_addr = block_q + (AW'(1) << tmp_o_q);
	assign lo_addr   = lo_bud_q ? bud_q : block_q;
	assign hdr_raddr = (state_q == ST_M_BRD) ? bud_q[AW-1:MIN_ORDER] : block_q[AW-1:MIN_ORDER];

	always_comb begin
		hdr_we    = 1'b0;
		hdr_waddr = block_q[AW-1:MIN_ORDER];
		hdr_wdata = {f_order_q, f_head_q, f_end_q, 1'b0};
		case (state_q)
			ST_A_GWR, ST_F_WR: begin
				hdr_we = 1'b1;
			end
			ST_SP_WRF: begin
				hdr_we    = 1'b1;
				hdr_wdata = {tmp_o_q, f_head_q, f_end_q, f_used_q};
			end
			ST_SP_WRB: begin
				hdr_we    = 1'b1;
				hdr_waddr = back_addr[AW-1:MIN_ORDER];
				hdr_wdata = {tmp_o_q, f_head_q, f_end_q, 1'b0};
			end
			ST_SP_USE: begin
				hdr_we    = 1'b1;
				hdr_wdata = {f_order_q, f_head_q, f_end_q, 1'b1};
			end
			ST_M_WR: begin
				hdr_we    = 1'b1;
				hdr_waddr = lo_addr[AW-1:MIN_ORDER];
				hdr_wdata = {tmp_o_q + ORDER_W'(1), f_head_q, f_end_q, 1'b0};
			end
			default: begin
				hdr_we = 1'b0;
			end
		endcase
	end

	bba_hdr_ram #(
		.ADDR_W (HIW),
		.DATA_W (HW)
	) u_hdr_ram (
		.clk   (clk),
		.we    (hdr_we),
		.waddr (hdr_waddr),
		.wdata (hdr_wdata),
		.raddr (hdr_raddr),
		.rdata (hdr_rdata)
	);

	// Area sizing for a heap extension.
	logic [SW-1:0] need;
	logic [SW-1:0] area_size;
	logic [SW-1:0] grow_next;
	logic          heap_full;

	always_comb begin
		need      = SW'(1) << k_q;
		grow_next = grow_q;
		if (need <= MIN_B) begin
			area_size = MIN_B;
		end else if (need >= MAX_B) begin
			area_size = need;
		end else if (need > grow_q) begin
			area_size = need;
			grow_next = ((grow_q << 1) < MAX_B) ? (grow_q << 1) : MAX_B;
		end else begin
			area_size = grow_q;
			grow_next = ((grow_q >> 1) > MIN_B) ? (grow_q >> 1) : MIN_B;
		end
		heap_full = (SW'(heap_top_q) + area_size) > HEAP_B;
	end

	// Request size and free address checks.
	logic [SW-1:0] req_total;
	logic [SW-1:0] ua_ext;
	logic [SW-1:0] blk_ext;

	assign req_total = SW'(req_q) + HDR_B;
	assign ua_ext    = SW'(ua_q);
	assign blk_ext   = ua_ext - HDR_B;

	// Buddy address: the block's position bit inside its area picks the side.
	logic [AW-1:0] area_off;
	logic          side_bit;
	logic [SW-1:0] step;
	logic [SW-1:0] buddy_ext;
	logic          buddy_out;

	assign area_off  = block_q - f_head_q;
	assign side_bit  = area_off[f_order_q[$clog2(AW)-1:0]];
	assign step      = SW'(1) << f_order_q;
	assign buddy_ext = side_bit ? (SW'(block_q) - step) : (SW'(block_q) + step);
	assign buddy_out = (buddy_ext < SW'(f_head_q)) || (buddy_ext >= SW'(f_end_q));

	// Main sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			req_q       <= '0;
			ua_q        <= '0;
			k_q         <= '0;
			block_q     <= '0;
			bud_q       <= '0;
			lo_bud_q    <= 1'b0;
			f_order_q   <= '0;
			f_head_q    <= '0;
			f_end_q     <= '0;
			f_used_q    <= 1'b0;
			tmp_o_q     <= '0;
			heap_top_q  <= '0;
			grow_q      <= MIN_B;
			sc_mode_q   <= SC_FIND;
			sc_ret_q    <= ST_IDLE;
			sc_order_q  <= '0;
			sc_key_q    <= '0;
			sc_idx_q    <= '0;
			sc_hit_q    <= '0;
			sc_found_q  <= 1'b0;
			sc_dup_q    <= 1'b0;
			sc_best_q   <= '0;
			clr_q       <= '0;
			for (int i = 0; i < NO; i++) begin
				cnt_q[i] <= '0;
			end
			hold_q      <= '0;
			rsp_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			// The output register empties when its word is taken, unless a new one is loaded.
			if (rsp_ready && (state_q != ST_FIN)) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + SAW'(1);
					if (clr_q == SAW'(NSLOT - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (req_valid) begin
						req_q   <= req_word.request_bytes;
						ua_q    <= req_word.user_address;
						state_q <= (req_word.operation == OP_ALLOC) ? ST_A_START : ST_F_START;
					end
				end
				ST_A_START: begin
					if (req_q == '0) begin
						hold_q  <= '{STATUS_REJECT, '0, '0};
						state_q <= ST_FIN;
					end else begin
						if (clog2_up(64'(req_total)) < ORDER_W'(MIN_ORDER)) begin
							k_q        <= ORDER_W'(MIN_ORDER);
							sc_order_q <= ORDER_W'(MIN_ORDER);
						end else begin
							k_q        <= clog2_up(64'(req_total));
							sc_order_q <= clog2_up(64'(req_total));
						end
						state_q <= ST_A_SEARCH;
					end
				end
				// Walk up the orders until a non-empty list is met.
				ST_A_SEARCH: begin
					if (sc_order_q > ORDER_W'(AW)) begin
						state_q <= ST_A_GROW;
					end else if (cnt_cur == '0) begin
						sc_order_q <= sc_order_q + ORDER_W'(1);
					end else begin
						sc_mode_q <= SC_FIND;
						sc_ret_q  <= ST_A_FOUND;
						state_q   <= ST_SC_START;
					end
				end
				ST_A_FOUND: begin
					if (sc_found_q) begin
						block_q <= sc_best_q;
						state_q <= ST_A_HRD;
					end else begin
						state_q <= ST_A_GROW;
					end
				end
				ST_A_HRD: begin
					state_q <= ST_A_HCAP;
				end
				ST_A_HCAP: begin
					f_order_q <= rd_order;
					f_head_q  <= rd_head;
					f_end_q   <= rd_end;
					f_used_q  <= rd_used;
					state_q   <= ST_SP_CHK;
				end
				// Open a new area at the top of the heap.
				ST_A_GROW: begin
					if (heap_full) begin
						hold_q  <= '{STATUS_OOM, '0, '0};
						state_q <= ST_FIN;
					end else begin
						grow_q     <= grow_next;
						block_q    <= AW'(heap_top_q);
						f_order_q  <= clog2_up(64'(area_size));
						f_head_q   <= AW'(heap_top_q);
						f_end_q    <= (AW + 1)'(SW'(heap_top_q) + area_size);
						f_used_q   <= 1'b0;
						heap_top_q <= (AW + 1)'(SW'(heap_top_q) + area_size);
						state_q    <= ST_A_GWR;
					end
				end
				ST_A_GWR: begin
					sc_mode_q  <= SC_ADD;
					sc_order_q <= f_order_q;
					sc_key_q   <= block_q;
					sc_ret_q   <= ST_SP_CHK;
					state_q    <= ST_SC_START;
				end
				// Halve the block until it has the wanted order.
				ST_SP_CHK: begin
					if ((f_order_q > k_q) && (f_order_q > ORDER_W'(MIN_ORDER))) begin
						tmp_o_q    <= f_order_q - ORDER_W'(1);
						sc_mode_q  <= SC_DEL;
						sc_order_q <= f_order_q;
						sc_key_q   <= block_q;
						sc_ret_q   <= ST_SP_A1;
						state_q    <= ST_SC_START;
					end else begin
						state_q <= ST_SP_USE;
					end
				end
				ST_SP_A1: begin
					sc_mode_q  <= SC_ADD;
					sc_order_q <= tmp_o_q;
					sc_key_q   <= block_q;
					sc_ret_q   <= ST_SP_WRF;
					state_q    <= ST_SC_START;
				end
				ST_SP_WRF: begin
					f_order_q <= tmp_o_q;
					state_q   <= ST_SP_WRB;
				end
				ST_SP_WRB: begin
					sc_mode_q  <= SC_ADD;
					sc_order_q <= tmp_o_q;
					sc_key_q   <= back_addr;
					sc_ret_q   <= ST_SP_CHK;
					state_q    <= ST_SC_START;
				end
				ST_SP_USE: begin
					sc_mode_q  <= SC_DEL;
					sc_order_q <= k_q;
					sc_key_q   <= block_q;
					sc_ret_q   <= ST_A_DONE;
					state_q    <= ST_SC_START;
				end
				ST_A_DONE: begin
					hold_q.status          <= STATUS_OK;
					hold_q.granted_address <= GADDR_W'(SW'(block_q) + HDR_B);
					hold_q.granted_order   <= GORDER_W'(k_q);
					state_q                <= ST_FIN;
				end
				// Free: check the address before touching any state.
				ST_F_START: begin
					if (ua_q == '0) begin
						hold_q  <= '{STATUS_OK, '0, '0};
						state_q <= ST_FIN;
					end else if ((ua_ext < HDR_B) || (blk_ext[MIN_ORDER-1:0] != '0) ||
						(blk_ext >= SW'(heap_top_q))) begin
						hold_q  <= '{STATUS_REJECT, '0, '0};
						state_q <= ST_FIN;
					end else begin
						block_q <= AW'(blk_ext);
						state_q <= ST_F_HRD;
					end
				end
				ST_F_HRD: begin
					state_q <= ST_F_HCAP;
				end
				ST_F_HCAP: begin
					f_order_q <= rd_order;
					f_head_q  <= rd_head;
					f_end_q   <= rd_end;
					f_used_q  <= rd_used;
					if ((rd_order < ORDER_W'(MIN_ORDER)) || (rd_order > ORDER_W'(AW)) ||
						(block_q < rd_head) || ((AW + 1)'(block_q) >= rd_end)) begin
						hold_q  <= '{STATUS_REJECT, '0, '0};
						state_q <= ST_FIN;
					end else begin
						state_q <= ST_F_WR;
					end
				end
				ST_F_WR: begin
					sc_mode_q  <= SC_ADD;
					sc_order_q <= f_order_q;
					sc_key_q   <= block_q;
					sc_ret_q   <= ST_M_CHK;
					state_q    <= ST_SC_START;
				end
				// Merge with the buddy while it is free and of equal order.
				ST_M_CHK: begin
					if ((f_order_q < ORDER_W'(AW)) && !buddy_out) begin
						bud_q   <= AW'(buddy_ext);
						state_q <= ST_M_BRD;
					end else begin
						hold_q  <= '{STATUS_OK, '0, '0};
						state_q <= ST_FIN;
					end
				end
				ST_M_BRD: begin
					state_q <= ST_M_BCAP;
				end
				ST_M_BCAP: begin
					if ((rd_order != f_order_q) || rd_used) begin
						hold_q  <= '{STATUS_OK, '0, '0};
						state_q <= ST_FIN;
					end else begin
						tmp_o_q  <= f_order_q;
						lo_bud_q <= bud_q < block_q;
						if (bud_q < block_q) begin
							f_head_q <= rd_head;
							f_end_q  <= rd_end;
						end
						sc_mode_q  <= SC_DEL;
						sc_order_q <= f_order_q;
						sc_key_q   <= block_q;
						sc_ret_q   <= ST_M_D2;
						state_q    <= ST_SC_START;
					end
				end
				ST_M_D2: begin
					sc_mode_q  <= SC_DEL;
					sc_order_q <= tmp_o_q;
					sc_key_q   <= bud_q;
					sc_ret_q   <= ST_M_WR;
					state_q    <= ST_SC_START;
				end
				ST_M_WR: begin
					block_q    <= lo_addr;
					f_order_q  <= tmp_o_q + ORDER_W'(1);
					sc_mode_q  <= SC_ADD;
					sc_order_q <= tmp_o_q + ORDER_W'(1);
					sc_key_q   <= lo_addr;
					sc_ret_q   <= ST_M_CHK;
					state_q    <= ST_SC_START;
				end
				// Row scan: skip rows that cannot change, else sweep every slot.
				ST_SC_START: begin
					sc_idx_q   <= '0;
					sc_hit_q   <= '0;
					sc_found_q <= 1'b0;
					sc_dup_q   <= 1'b0;
					if (!ord_ok || ((sc_mode_q == SC_ADD) &&
						(cnt_cur >= CW'(SLOTS_PER_ORDER)))) begin
						state_q <= sc_ret_q;
					end else begin
						state_q <= ST_SC_RD;
					end
				end
				ST_SC_RD: begin
					state_q <= ST_SC_CHK;
				end
				ST_SC_CHK: begin
					case (sc_mode_q)
						SC_FIND: begin
							if (sl_valid && (!sc_found_q || (sl_addr < sc_best_q))) begin
								sc_best_q  <= sl_addr;
								sc_found_q <= 1'b1;
							end
						end
						SC_ADD: begin
							if (sl_valid && (sl_addr == sc_key_q)) begin
								sc_dup_q <= 1'b1;
							end
							if (!sl_valid && !sc_found_q) begin
								sc_found_q <= 1'b1;
								sc_hit_q   <= sc_idx_q;
							end
						end
						SC_DEL: begin
							if (sl_valid && (sl_addr == sc_key_q) && !sc_found_q) begin
								sc_found_q <= 1'b1;
								sc_hit_q   <= sc_idx_q;
							end
						end
						default: begin
							sc_found_q <= sc_found_q;
						end
					endcase
					if (sc_idx_q == SIW'(SLOTS_PER_ORDER - 1)) begin
						state_q <= ST_SC_END;
					end else begin
						sc_idx_q <= sc_idx_q + SIW'(1);
						state_q  <= ST_SC_RD;
					end
				end
				ST_SC_END: begin
					if ((sc_mode_q == SC_ADD) && !sc_dup_q && sc_found_q) begin
						cnt_q[oi] <= cnt_cur + CW'(1);
					end else if ((sc_mode_q == SC_DEL) && sc_found_q && (cnt_cur != '0)) begin
						cnt_q[oi] <= cnt_cur - CW'(1);
					end
					state_q <= sc_ret_q;
				end
				// Hand the word to the output register once it is free.
				ST_FIN: begin
					if (!rsp_valid_q || rsp_ready) begin
						rsp_q       <= hold_q;
						rsp_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign req_ready = (state_q == ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp_word  = rsp_q;

	// The heap never grows past the address space.
	a_heap_bound: assert property (@(posedge clk) disable iff (!arst_n)
		SW'(heap_top_q) <= HEAP_B)
		else $error("heap top beyond address space");

	// The adaptive area size never drops below its floor.
	a_grow_floor: assert property (@(posedge clk) disable iff (!arst_n)
		grow_q >= MIN_B)
		else $error("grow size below floor");

	// A list never counts more entries than it has slots.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_cur <= CW'(SLOTS_PER_ORDER))
		else $error("free list count beyond slot count");

	// Only a good allocate carries an address and an order.
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && (rsp_q.status != STATUS_OK) |->
		(rsp_q.granted_address == '0) && (rsp_q.granted_order == '0))
		else $error("failed response carries an address");

	// No response is shown while the slot sweep runs.
	a_clear_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLR) |=> !rsp_valid_q)
		else $error("response during slot sweep");

endmodule
